// ----- design/aes_pkg.sv -----
// Shared types, constants and byte functions for the AES-128 block encryptor.
package aes_pkg;

    localparam int HalfWidth  = 64;
    localparam int BlockWidth = 128;
    localparam int CfgIdxWidth = 1;
    localparam int NumRounds  = 10;
    localparam int RoundWidth = 4;

    localparam logic [CfgIdxWidth-1:0] CfgKeyUpper = 1'b0;
    localparam logic [CfgIdxWidth-1:0] CfgKeyLower = 1'b1;

    typedef struct packed {
        logic [HalfWidth-1:0] text_half;
        logic                 second_half;
    } aes_in_t;

    typedef struct packed {
        logic [HalfWidth-1:0] cipher_half;
        logic                 last_half;
    } aes_out_t;

    // controller -> datapath
    typedef struct packed {
        logic hold_first;
        logic load;
        logic round;
        logic last_round;
        logic emit_first;
        logic emit_second;
    } aes_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ----- design/aes128_block_encryptor_top.sv -----
// AES-128 block encryptor: a first half is taken and held. A second half
// loads the block at its accepting edge (initial AddRoundKey) and keeps busy
// high through ten rounds (one round of the shared round unit per cycle) and
// the two emit states for the ciphertext halves. The halves come out
// registered from ST_EMIT1 and then ST_EMIT2, first half first, each on result
// for one cycle under done. A new request can be taken while the second half
// is still on result. The receiver cannot stall; results are never held.
module aes128_block_encryptor_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [aes_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [aes_pkg::HalfWidth-1:0]     cfg_data,
    input  logic                              start,
    input  aes_pkg::aes_in_t                  request,
    output logic                              busy,
    output logic                              done,
    output aes_pkg::aes_out_t                 result
);
    import aes_pkg::*;

    aes_cmd_t cmd;

    aes_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .second_half (request.second_half),
        .busy        (busy),
        .cmd         (cmd)
    );

    aes_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text_half (request.text_half),
        .cmd       (cmd),
        .done      (done),
        .result    (result)
    );

endmodule

// ----- design/aes_ctrl.sv -----
// Sequencer for the AES-128 encryptor: load, ten rounds, two result halves.
module aes_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                second_half,
    output logic                busy,
    output aes_pkg::aes_cmd_t   cmd
);
    import aes_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ROUND  = 4'b0010,
        ST_EMIT1  = 4'b0100,
        ST_EMIT2  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [RoundWidth-1:0] round_reg, round_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (second_half)
                    begin
                        cmd.load   = 1'b1;
                        round_next = RoundWidth'(1);
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        cmd.hold_first = 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.round      = 1'b1;
                cmd.last_round = (round_reg == RoundWidth'(NumRounds));
                round_next     = round_reg + RoundWidth'(1);
                if (cmd.last_round)
                    state_next = ST_EMIT1;
            end
            ST_EMIT1:
            begin
                cmd.emit_first = 1'b1;
                state_next     = ST_EMIT2;
            end
            ST_EMIT2:
            begin
                cmd.emit_second = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/aes_datapath.sv -----
// Key registers, state and round-key registers and one AES round per cycle.
module aes_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [aes_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [aes_pkg::HalfWidth-1:0]     cfg_data,
    input  logic [aes_pkg::HalfWidth-1:0]     text_half,
    input  aes_pkg::aes_cmd_t                 cmd,
    output logic                              done,
    output aes_pkg::aes_out_t                 result
);
    import aes_pkg::*;

    logic [HalfWidth-1:0]  key_upper_reg, key_lower_reg, held_reg;
    logic [BlockWidth-1:0] state_reg, key_reg;
    logic [7:0]            rcon_reg;
    logic                  done_reg;
    aes_out_t              result_reg;

    logic [7:0] s [16];
    logic [7:0] k [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] nk [16];
    logic [7:0] kt [4];
    logic [BlockWidth-1:0] state_next, key_next;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_reg[BlockWidth-1-8*i -: 8];
            k[i] = key_reg[BlockWidth-1-8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] all;
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            for (int r = 0; r < 4; r++)
                m[4*c+r] = cmd.last_round ? t[4*c+r]
                         : t[4*c+r] ^ all ^ xtime(t[4*c+r] ^ t[4*c+((r+1)%4)]);
        end
        kt[0] = SBOX[k[13]] ^ rcon_reg;
        kt[1] = SBOX[k[14]];
        kt[2] = SBOX[k[15]];
        kt[3] = SBOX[k[12]];
        for (int i = 0; i < 4; i++)
            nk[i] = k[i] ^ kt[i];
        for (int i = 4; i < 16; i++)
            nk[i] = k[i] ^ nk[i-4];
        for (int i = 0; i < 16; i++)
        begin
            key_next[BlockWidth-1-8*i -: 8]   = nk[i];
            state_next[BlockWidth-1-8*i -: 8] = m[i] ^ nk[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
            held_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CfgKeyUpper: key_upper_reg <= cfg_data;
                    CfgKeyLower: key_lower_reg <= cfg_data;
                    default:     key_upper_reg <= key_upper_reg;
                endcase
            end
            if (cmd.hold_first)
                held_reg <= text_half;
            done_reg <= cmd.emit_first | cmd.emit_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            key_reg    <= '0;
            rcon_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                // initial AddRoundKey
                state_reg <= {held_reg, text_half} ^ {key_upper_reg, key_lower_reg};
                key_reg   <= {key_upper_reg, key_lower_reg};
                rcon_reg  <= 8'h01;
            end
            else if (cmd.round)
            begin
                state_reg <= state_next;
                key_reg   <= key_next;
                rcon_reg  <= xtime(rcon_reg);
            end
            if (cmd.emit_first)
                result_reg <= '{cipher_half: state_reg[BlockWidth-1 -: HalfWidth],
                                last_half: 1'b0};
            else if (cmd.emit_second)
                result_reg <= '{cipher_half: state_reg[HalfWidth-1:0], last_half: 1'b1};
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
